@@ rtl/naca4_pkg.sv @@
// ============================================================================
// naca4_pkg - shared types, constants and stage functions
// Item record carried down the surface point pipeline, the per-stage step
// function, and the fixed-point constants (Q30 internal format).
// ============================================================================
package naca4_pkg;

  localparam int MAX_STATIONS = 1024;
  localparam int FRAC_BITS    = 16;
  localparam int IQ           = 30;
  localparam int RND_SH       = IQ - FRAC_BITS;

  localparam logic [30:0] ONE_Q = 31'h4000_0000;
  localparam logic [31:0] PI_Q  = 32'd3373259426;

  // thickness polynomial coefficients, 5x scale folded into t later
  localparam logic [31:0] C_SQRT = 32'd318793948;
  localparam logic [31:0] C_LIN  = 32'd135291470;
  localparam logic [31:0] C_SQR  = 32'd377527625;
  localparam logic [31:0] C_CUB  = 32'd305264801;
  localparam logic [31:0] C_QUA  = 32'd111239653;

  localparam logic signed [35:0] OUT_MAX = 36'sd524287;
  localparam logic signed [35:0] OUT_MIN = -36'sd524288;

  // Taylor term divisors (2k)(2k+1), as exact reciprocals for 33-bit terms
  localparam int SIN_SH [7] = '{36, 38, 39, 40, 40, 41, 41};
  localparam logic [34:0] SIN_RCP [7] = '{
    35'(((64'd1 << 36) + 64'd5)   / 64'd6),
    35'(((64'd1 << 38) + 64'd19)  / 64'd20),
    35'(((64'd1 << 39) + 64'd41)  / 64'd42),
    35'(((64'd1 << 40) + 64'd71)  / 64'd72),
    35'(((64'd1 << 40) + 64'd109) / 64'd110),
    35'(((64'd1 << 41) + 64'd155) / 64'd156),
    35'(((64'd1 << 41) + 64'd209) / 64'd210)
  };

  // stage map
  localparam int K_D1 = 1;               // station angle divide
  localparam int D1_N = 31;
  localparam int K_SN = K_D1 + D1_N;     // sine series, 3 stages per term
  localparam int K_SQ = K_SN + 21;       // x = sin^2
  localparam int K_CB = K_SQ + 1;        // camber branch select
  localparam int K_BG = K_CB + 1;        // ratio overflow check
  localparam int K_RD = K_BG + 1;        // ratio divide
  localparam int RD_N = 31;
  localparam int K_XS = K_RD;            // sqrt(x), alongside ratio divide
  localparam int XS_N = 32;
  localparam int K_RT = K_RD + RD_N;
  localparam int K_M1 = K_RT + 1;
  localparam int K_M2 = K_M1 + 1;
  localparam int K_SD = K_M2 + 1;        // slope divide, poly alongside
  localparam int SD_N = 47;
  localparam int K_SL = K_SD + SD_N;
  localparam int K_WD = K_SL + 1;        // reciprocal slope divide
  localparam int WD_N = 30;
  localparam int K_V  = K_WD + WD_N;
  localparam int K_H  = K_V + 1;
  localparam int K_HS = K_H + 1;         // hypotenuse sqrt
  localparam int HS_N = 32;
  localparam int K_C  = K_HS + HS_N;
  localparam int K_CD = K_C + 1;         // cos/sin divides
  localparam int CD_N = 31;
  localparam int K_CS = K_CD + CD_N;
  localparam int K_D  = K_CS + 1;
  localparam int K_P  = K_D + 1;
  localparam int K_O  = K_P + 1;
  localparam int NST  = K_O + 1;

  typedef enum logic [1:0] {
    REG_NUM_STATIONS    = 2'd0,
    REG_MAX_CAMBER      = 2'd1,
    REG_CAMBER_POSITION = 2'd2,
    REG_THICKNESS_RATIO = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] num_stations;
    logic [14:0] max_camber;
    logic [15:0] camber_position;
    logic [14:0] thickness_ratio;
  } cfg_t;

  typedef struct packed {
    logic               upper;
    logic               zero;
    logic               sat;
    logic               rising;
    logic               big;
    logic               big2;
    logic [41:0]        num1;
    logic [10:0]        dv;
    logic [30:0]        u;
    logic [32:0]        term;
    logic signed [34:0] sum;
    logic [30:0]        x;
    logic [16:0]        d16;
    logic [46:0]        rrem;
    logic [30:0]        ratio;
    logic [63:0]        sxr;
    logic [63:0]        sxv;
    logic [30:0]        rsq;
    logic [46:0]        srem;
    logic [46:0]        slope;
    logic [30:0]        yc;
    logic [30:0]        x2;
    logic [30:0]        x3;
    logic [30:0]        x4;
    logic [31:0]        pa;
    logic [31:0]        pb;
    logic [31:0]        pc;
    logic [31:0]        pd;
    logic [31:0]        pe;
    logic signed [33:0] poly;
    logic signed [35:0] yt;
    logic [60:0]        wrem;
    logic [29:0]        w;
    logic [30:0]        v;
    logic [63:0]        shr;
    logic [63:0]        shv;
    logic [30:0]        h;
    logic [60:0]        c1rem;
    logic [60:0]        c2rem;
    logic [30:0]        c1;
    logic [30:0]        c2;
    logic [30:0]        cosv;
    logic [30:0]        sinv;
    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic signed [35:0] px;
    logic signed [35:0] py;
    logic [19:0]        ox;
    logic [19:0]        oy;
  } item_t;

  typedef struct packed {
    logic [63:0] r;
    logic [63:0] v;
  } sq_t;

  // one restoring divide step: {quotient bit, new remainder}
  function automatic logic [80:0] div_step(input logic [79:0] rem, input logic [79:0] dsh);
    logic [80:0] res;
    if (rem >= dsh) begin
      res = {1'b1, rem - dsh};
    end else begin
      res = {1'b0, rem};
    end
    return res;
  endfunction

  // one digit of the floor square root, test bit 4^(31-j)
  function automatic sq_t sqrt_step(input logic [63:0] r, input logic [63:0] v, input int j);
    sq_t         res;
    logic [63:0] bt;
    bt = 64'd1 << (62 - 2 * j);
    if (v >= r + bt) begin
      res.v = v - (r + bt);
      res.r = (r >> 1) + bt;
    end else begin
      res.v = v;
      res.r = r >> 1;
    end
    return res;
  endfunction

  // entry stage: clamp station, form pi*i and the 2(N-1) divisor
  function automatic item_t prep(input logic [9:0] idx, input logic upper, input cfg_t c);
    item_t       r;
    logic [10:0] n;
    logic [9:0]  nm1;
    logic [9:0]  i;
    r   = '0;
    n   = (c.num_stations > 11'(MAX_STATIONS)) ? 11'(MAX_STATIONS) : c.num_stations;
    nm1 = 10'(n - 11'd1);
    r.zero  = (n < 11'd2);
    r.sat   = r.zero;
    r.upper = upper;
    i       = r.zero ? 10'd0 : ((idx > nm1) ? nm1 : idx);
    r.dv    = r.zero ? 11'd1 : {nm1, 1'b0};
    r.num1  = 42'(PI_Q) * 42'(i);
    return r;
  endfunction

  // work done by pipeline stage k (k is fixed per instance)
  function automatic item_t stage_step(input int k, input item_t a, input cfg_t c);
    item_t              r;
    int                 b;
    int                 j;
    logic [80:0]        ds;
    logic [80:0]        ds2;
    logic [79:0]        dsor;
    logic [32:0]        tin;
    logic [67:0]        p68;
    logic [30:0]        q;
    logic signed [34:0] sb;
    logic [30:0]        s;
    logic [30:0]        pq;
    logic [30:0]        dlt;
    logic [17:0]        t5;
    logic signed [53:0] yp;
    logic signed [67:0] mp;
    logic signed [35:0] dxa;
    logic signed [35:0] rx;
    logic signed [35:0] ry;
    sq_t                sq;
    r = a;

    if (k >= K_D1 && k < K_D1 + D1_N) begin
      b = D1_N - 1 - (k - K_D1);
      ds = div_step(80'(a.num1), 80'(a.dv) << b);
      r.num1 = ds[41:0];
      r.u[b] = ds[80];
    end

    for (int t = 0; t < 7; t++) begin
      if (k == K_SN + 3 * t) begin
        tin    = (t == 0) ? 33'(a.u) : a.term;
        r.term = 33'((64'(tin) * 64'(a.u)) >> IQ);
      end
      if (k == K_SN + 3 * t + 1) begin
        r.term = 33'((64'(a.term) * 64'(a.u)) >> IQ);
      end
      if (k == K_SN + 3 * t + 2) begin
        p68    = 68'(a.term) * 68'(SIN_RCP[t]);
        q      = 31'(p68 >> SIN_SH[t]);
        r.term = 33'(q);
        sb     = (t == 0) ? $signed(35'(a.u)) : a.sum;
        r.sum  = ((t & 1) == 0) ? sb - $signed(35'(q)) : sb + $signed(35'(q));
      end
    end

    if (k == K_SQ) begin
      if (a.sum < 0) begin
        s = '0;
      end else if (a.sum > $signed(35'(ONE_Q))) begin
        s = ONE_Q;
      end else begin
        s = 31'(a.sum);
      end
      r.x = a.zero ? 31'd0 : 31'((64'(s) * 64'(s)) >> IQ);
    end

    if (k == K_CB) begin
      pq       = 31'(c.camber_position) << 14;
      r.rising = a.x < pq;
      r.d16    = r.rising ? 17'(c.camber_position) : 17'h10000 - 17'(c.camber_position);
      dlt      = r.rising ? pq - a.x : a.x - pq;
      r.rrem   = 47'(dlt) << 16;
      r.ratio  = '0;
      r.sxv    = 64'(a.x) << IQ;
      r.sxr    = '0;
    end

    if (k == K_BG) begin
      r.big = 80'(a.rrem) >= (80'(a.d16) << IQ) + 80'(a.d16);
    end

    if (k >= K_RD && k < K_RD + RD_N) begin
      b = RD_N - 1 - (k - K_RD);
      ds = div_step(80'(a.rrem), 80'(a.d16) << b);
      r.rrem     = ds[46:0];
      r.ratio[b] = ds[80];
    end

    if (k >= K_XS && k < K_XS + XS_N) begin
      j     = k - K_XS;
      sq    = sqrt_step(a.sxr, a.sxv, j);
      r.sxr = sq.r;
      r.sxv = sq.v;
    end

    if (k == K_RT && a.big) begin
      r.ratio = ONE_Q;
    end

    if (k == K_M1) begin
      r.rsq   = 31'((64'(a.ratio) * 64'(a.ratio)) >> IQ);
      r.srem  = 47'(a.ratio) * 47'({c.max_camber, 1'b0});
      r.slope = '0;
      r.x2    = 31'((64'(a.x) * 64'(a.x)) >> IQ);
    end

    if (k == K_M2) begin
      r.yc = 31'((64'(c.max_camber) * 64'(ONE_Q - a.rsq)) >> 16);
      r.x3 = 31'((64'(a.x2) * 64'(a.x)) >> IQ);
    end

    if (k >= K_SD && k < K_SD + SD_N) begin
      b = SD_N - 1 - (k - K_SD);
      ds = div_step(80'(a.srem), 80'(a.d16) << b);
      r.srem     = ds[46:0];
      r.slope[b] = ds[80];
    end

    if (k == K_SD) begin
      r.x4 = 31'((64'(a.x3) * 64'(a.x)) >> IQ);
    end
    if (k == K_SD + 1) begin
      r.pa = 32'((64'(C_SQRT) * 64'(a.sxr[30:0])) >> IQ);
      r.pb = 32'((64'(C_LIN) * 64'(a.x)) >> IQ);
      r.pc = 32'((64'(C_SQR) * 64'(a.x2)) >> IQ);
      r.pd = 32'((64'(C_CUB) * 64'(a.x3)) >> IQ);
      r.pe = 32'((64'(C_QUA) * 64'(a.x4)) >> IQ);
    end
    if (k == K_SD + 2) begin
      r.poly = $signed(34'(a.pa)) - $signed(34'(a.pb)) - $signed(34'(a.pc))
             + $signed(34'(a.pd)) - $signed(34'(a.pe));
    end
    if (k == K_SD + 3) begin
      t5   = 18'(c.thickness_ratio) * 18'd5;
      yp   = 54'(a.poly) * $signed(54'(t5));
      r.yt = 36'(yp >>> 16);
    end

    if (k == K_SL) begin
      r.big2 = a.slope > 47'(ONE_Q);
      r.wrem = 61'd1 << 60;
      r.w    = '0;
    end

    if (k >= K_WD && k < K_WD + WD_N) begin
      b    = WD_N - 1 - (k - K_WD);
      dsor = a.big2 ? 80'(a.slope) : (80'd1 << 31);
      ds   = div_step(80'(a.wrem), dsor << b);
      r.wrem = ds[60:0];
      r.w[b] = ds[80];
    end

    if (k == K_V) begin
      r.v = a.big2 ? {1'b0, a.w} : a.slope[30:0];
    end

    if (k == K_H) begin
      r.shv = (64'd1 << 60) + 64'(a.v) * 64'(a.v);
      r.shr = '0;
    end

    if (k >= K_HS && k < K_HS + HS_N) begin
      j     = k - K_HS;
      sq    = sqrt_step(a.shr, a.shv, j);
      r.shr = sq.r;
      r.shv = sq.v;
    end

    if (k == K_C) begin
      r.h     = a.shr[30:0];
      r.c1rem = 61'd1 << 60;
      r.c2rem = 61'(a.v) << IQ;
      r.c1    = '0;
      r.c2    = '0;
    end

    if (k >= K_CD && k < K_CD + CD_N) begin
      b   = CD_N - 1 - (k - K_CD);
      ds  = div_step(80'(a.c1rem), 80'(a.h) << b);
      ds2 = div_step(80'(a.c2rem), 80'(a.h) << b);
      r.c1rem = ds[60:0];
      r.c1[b] = ds[80];
      r.c2rem = ds2[60:0];
      r.c2[b] = ds2[80];
    end

    if (k == K_CS) begin
      r.cosv = a.big2 ? a.c2 : a.c1;
      r.sinv = a.big2 ? a.c1 : a.c2;
    end

    if (k == K_D) begin
      mp   = 68'(a.yt) * $signed(68'(a.sinv));
      r.dx = 36'(mp >>> IQ);
      mp   = 68'(a.yt) * $signed(68'(a.cosv));
      r.dy = 36'(mp >>> IQ);
    end

    if (k == K_P) begin
      dxa  = a.rising ? a.dx : -a.dx;
      r.px = a.upper ? $signed(36'(a.x)) - dxa : $signed(36'(a.x)) + dxa;
      r.py = a.upper ? $signed(36'(a.yc)) + a.dy : $signed(36'(a.yc)) - a.dy;
    end

    if (k == K_O) begin
      rx = (a.px + (36'sd1 <<< (RND_SH - 1))) >>> RND_SH;
      ry = (a.py + (36'sd1 <<< (RND_SH - 1))) >>> RND_SH;
      if (rx > OUT_MAX) begin
        rx    = OUT_MAX;
        r.sat = 1'b1;
      end else if (rx < OUT_MIN) begin
        rx    = OUT_MIN;
        r.sat = 1'b1;
      end
      if (ry > OUT_MAX) begin
        ry    = OUT_MAX;
        r.sat = 1'b1;
      end else if (ry < OUT_MIN) begin
        ry    = OUT_MIN;
        r.sat = 1'b1;
      end
      r.ox = rx[19:0];
      r.oy = ry[19:0];
    end

    return r;
  endfunction

endpackage

@@ rtl/naca_four_digit_surface_point.sv @@
// ============================================================================
// naca_four_digit_surface_point - NACA 4-digit airfoil surface point pipeline
// Maps a station index and surface select to one (x, y) point on the section,
// using cosine spacing, the closed-trailing-edge thickness polynomial and the two-branch
// camber line, all in Q30 fixed point.
// ============================================================================
//
// Channel   Dir  Handshake            Payload
// --------  ---  -------------------  ----------------------------------------
// s_*       in   s_tvalid/s_tready    tdata: station; tuser: surface
// m_*       out  m_tvalid/m_tready    tdata: point_x, point_y; tuser: saturated
// APB       in   psel/penable/pwrite  4 registers at byte offsets 0,4,8,12
//
// One transfer per clock is taken and one result per clock is delivered while the output is not stalled.
// The pipeline depth is set by
// the bit-per-stage dividers (station angle, camber ratio, slope, reciprocal
// slope, cos/sin) and the two digit-per-stage square roots.
// The whole pipeline advances together whenever the output register is empty
// or its result is taken, so a stall holds every item in place.
// rst (synchronous) clears the valid bits and loads the register defaults.

module naca_four_digit_surface_point (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] station, [15:10] zero
  input  logic [0:0]  s_tuser,   // [0] surface (0 lower, 1 upper)
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [19:0] point_x, [39:20] point_y
  output logic [0:0]  m_tuser    // [0] saturated
);

  localparam int NST = naca4_pkg::NST;

  naca4_pkg::cfg_t  cfg;
  naca4_pkg::item_t pipe [NST];
  logic [NST-1:0]   vld;
  logic             adv;
  logic             wr_en;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_stations    <= 11'd101;
      cfg.max_camber      <= 15'd0;
      cfg.camber_position <= 16'd26214;
      cfg.thickness_ratio <= 15'd7864;
    end else if (wr_en) begin
      unique case (naca4_pkg::reg_idx_t'(paddr[3:2]))
        naca4_pkg::REG_NUM_STATIONS:    cfg.num_stations    <= pwdata[10:0];
        naca4_pkg::REG_MAX_CAMBER:      cfg.max_camber      <= pwdata[14:0];
        naca4_pkg::REG_CAMBER_POSITION: cfg.camber_position <= pwdata[15:0];
        naca4_pkg::REG_THICKNESS_RATIO: cfg.thickness_ratio <= pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (naca4_pkg::reg_idx_t'(paddr[3:2]))
      naca4_pkg::REG_NUM_STATIONS:    prdata = 32'(cfg.num_stations);
      naca4_pkg::REG_MAX_CAMBER:      prdata = 32'(cfg.max_camber);
      naca4_pkg::REG_CAMBER_POSITION: prdata = 32'(cfg.camber_position);
      naca4_pkg::REG_THICKNESS_RATIO: prdata = 32'(cfg.thickness_ratio);
    endcase
  end

  // -------------------------------------------------------------- pipeline
  // global advance: the last stage is the output register
  assign adv      = ~vld[NST-1] | m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // stage 0: station clamp and pi*i product
  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= naca4_pkg::prep(s_tdata[9:0], s_tuser[0], cfg);
    end
  end

  for (genvar k = 1; k < NST; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[k] <= naca4_pkg::stage_step(k, pipe[k-1], cfg);
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign m_tvalid   = vld[NST-1];
  assign m_tdata    = {pipe[NST-1].oy, pipe[NST-1].ox};
  assign m_tuser[0] = pipe[NST-1].sat;

endmodule
